// File: src/r64enc_pkg.sv
package r64enc_pkg;

	localparam int SCALE_BITS   = 14;
	localparam int ALPHABET     = 256;
	localparam int SYM_W        = 8;
	localparam int FREQ_W       = 15;
	localparam int START_W      = 14;
	localparam int STATE_W      = 64;
	localparam int WORD_W       = 32;
	localparam int IDX_W        = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int RENORM_SHIFT = STATE_W - 1 - SCALE_BITS;
	localparam int DIV_STEPS    = STATE_W;
	localparam int CNT_W        = $clog2(DIV_STEPS);

	localparam logic [STATE_W-1:0] STATE_LOW = STATE_W'(64'h0000_0000_8000_0000);

	typedef enum logic [1:0] {
		KIND_ENCODE = 2'd0,
		KIND_FLUSH  = 2'd1,
		KIND_TABLE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DIVIDE,
		ST_FLUSH_HI,
		ST_FLUSH_LO
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [SYM_W-1:0]   symbol;
		logic [FREQ_W-1:0]  entry_freq;
		logic [START_W-1:0] entry_start;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
		logic              zero_freq_error;
	} out_beat_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [START_W-1:0] start;
	} tbl_entry_t;

endpackage

// File: src/r64enc_in_if.sv
interface r64enc_in_if;
	logic                 valid;
	logic                 ready;
	r64enc_pkg::in_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/r64enc_out_if.sv
interface r64enc_out_if;
	logic                  valid;
	logic                  ready;
	r64enc_pkg::out_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/rans64_symbol_encoder_unit.sv
// 64-bit rANS encoder with 32-bit renormalization. Load the symbol table with table-write
// beats, then feed symbols in reverse message order and finish with a flush, which gives the
// high word and then the low word (marked last) of the final state and restarts the state at
// 2^31. One item is handled at a time. A table write completes as it is accepted. A flush
// emits the high word, then the low word, each waiting for the output register. An encode
// accepts the symbol, reads the table memory and, when it renormalizes, waits for the output
// register; then the restoring divider makes one quotient bit per cycle.
// A zero-frequency symbol returns a flagged zero word after the table read and leaves the
// state as it was. The single output register lets a result wait while the next item starts.
module rans64_symbol_encoder_unit (
	input logic              clk,
	input logic              arst_n,
	r64enc_in_if.sink        items,
	r64enc_out_if.source     results
);

	r64enc_pkg::state_t st_q, st_d;

	// symbol table
	r64enc_pkg::tbl_entry_t tbl_mem [r64enc_pkg::ALPHABET];
	r64enc_pkg::tbl_entry_t rd_q;
	logic                   oor_q;
	logic [r64enc_pkg::IDX_W-1:0] tbl_idx;
	logic                   in_range;
	logic                   wr_en;
	logic                   rd_en;

	// coder and divider
	logic [r64enc_pkg::STATE_W-1:0] coder_q;
	logic [r64enc_pkg::STATE_W-1:0] dvd_q;
	logic [r64enc_pkg::FREQ_W-1:0]  rem_q;
	logic [r64enc_pkg::FREQ_W-1:0]  freq_q;
	logic [r64enc_pkg::START_W-1:0] start_q;
	logic [r64enc_pkg::CNT_W-1:0]   cnt_q;

	logic [r64enc_pkg::FREQ_W-1:0]  lk_freq;
	logic                           lk_zero;
	logic                           lk_renorm;
	logic [r64enc_pkg::FREQ_W:0]    rem_shift;
	logic                           rem_ge;
	logic [r64enc_pkg::FREQ_W-1:0]  rem_next;
	logic [r64enc_pkg::STATE_W-1:0] dvd_next;

	logic                           div_start;
	logic                           div_last;
	logic                           state_reset;

	// output register
	logic                  out_valid_q;
	r64enc_pkg::out_beat_t out_data_q;
	logic                  out_free;
	logic                  emit;
	r64enc_pkg::out_beat_t emit_data;

	assign in_range = {1'b0, items.data.symbol} < (r64enc_pkg::SYM_W + 1)'(r64enc_pkg::ALPHABET);
	assign tbl_idx  = r64enc_pkg::IDX_W'(items.data.symbol);

	assign lk_freq   = oor_q ? '0 : rd_q.freq;
	assign lk_zero   = (lk_freq == '0);
	// exact form of x >= freq << (63 - SCALE_BITS)
	assign lk_renorm = (coder_q >> r64enc_pkg::RENORM_SHIFT) >= r64enc_pkg::STATE_W'(lk_freq);

	assign rem_shift = {rem_q, dvd_q[r64enc_pkg::STATE_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, freq_q};
	assign rem_next  = rem_ge ? r64enc_pkg::FREQ_W'(rem_shift - {1'b0, freq_q})
	                          : r64enc_pkg::FREQ_W'(rem_shift);
	assign dvd_next  = {dvd_q[r64enc_pkg::STATE_W-2:0], rem_ge};

	assign out_free      = !out_valid_q || results.ready;
	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= r64enc_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d        = st_q;
		items.ready = (st_q == r64enc_pkg::ST_IDLE);
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		div_start   = 1'b0;
		div_last    = 1'b0;
		state_reset = 1'b0;
		emit        = 1'b0;
		emit_data   = '0;
		unique case (st_q)
			r64enc_pkg::ST_IDLE: begin
				if (items.valid) begin
					unique case (items.data.kind)
						r64enc_pkg::KIND_ENCODE: begin
							rd_en = 1'b1;
							st_d  = r64enc_pkg::ST_LOOKUP;
						end
						r64enc_pkg::KIND_FLUSH: begin
							st_d = r64enc_pkg::ST_FLUSH_HI;
						end
						r64enc_pkg::KIND_TABLE: begin
							wr_en = in_range;
						end
						default: ;
					endcase
				end
			end
			r64enc_pkg::ST_LOOKUP: begin
				if (lk_zero) begin
					if (out_free) begin
						emit                      = 1'b1;
						emit_data.zero_freq_error = 1'b1;
						st_d                      = r64enc_pkg::ST_IDLE;
					end
				end else if (lk_renorm) begin
					if (out_free) begin
						emit           = 1'b1;
						emit_data.word = coder_q[r64enc_pkg::WORD_W-1:0];
						div_start      = 1'b1;
						st_d           = r64enc_pkg::ST_DIVIDE;
					end
				end else begin
					div_start = 1'b1;
					st_d      = r64enc_pkg::ST_DIVIDE;
				end
			end
			r64enc_pkg::ST_DIVIDE: begin
				if (cnt_q == '0) begin
					div_last = 1'b1;
					st_d     = r64enc_pkg::ST_IDLE;
				end
			end
			r64enc_pkg::ST_FLUSH_HI: begin
				if (out_free) begin
					emit           = 1'b1;
					emit_data.word = coder_q[r64enc_pkg::STATE_W-1:r64enc_pkg::WORD_W];
					st_d           = r64enc_pkg::ST_FLUSH_LO;
				end
			end
			r64enc_pkg::ST_FLUSH_LO: begin
				if (out_free) begin
					emit           = 1'b1;
					emit_data.word = coder_q[r64enc_pkg::WORD_W-1:0];
					emit_data.last = 1'b1;
					state_reset    = 1'b1;
					st_d           = r64enc_pkg::ST_IDLE;
				end
			end
			default: st_d = r64enc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[tbl_idx] <= '{freq: items.data.entry_freq, start: items.data.entry_start};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= tbl_mem[tbl_idx];
			oor_q <= !in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coder_q <= r64enc_pkg::STATE_LOW;
			cnt_q   <= '0;
		end else begin
			if (state_reset) begin
				coder_q <= r64enc_pkg::STATE_LOW;
			end else if (div_last) begin
				coder_q <= (dvd_next << r64enc_pkg::SCALE_BITS)
				         + r64enc_pkg::STATE_W'(rem_next)
				         + r64enc_pkg::STATE_W'(start_q);
			end
			if (div_start) begin
				cnt_q <= r64enc_pkg::CNT_W'(r64enc_pkg::DIV_STEPS - 1);
			end else if (st_q == r64enc_pkg::ST_DIVIDE) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			freq_q  <= lk_freq;
			start_q <= rd_q.start;
			rem_q   <= '0;
			dvd_q   <= lk_renorm ? (coder_q >> r64enc_pkg::WORD_W) : coder_q;
		end else if (st_q == r64enc_pkg::ST_DIVIDE) begin
			rem_q <= rem_next;
			dvd_q <= dvd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_data;
		end
	end

endmodule
